### rtl/v6p_pkg.sv
// ----------------------------------------------------------------------------
// v6p_pkg: shared types and constants for the IPv6 text address parser
// Item structs, status codes, parser state and character codes.
// ----------------------------------------------------------------------------
package v6p_pkg;

	// Longest address text accepted, in characters
	localparam int MAX_CHARS = 63;
	localparam int CNT_W     = $clog2(MAX_CHARS + 1);

	// Address geometry
	localparam int GROUPS  = 8;
	localparam int GROUP_W = 16;
	localparam int ADDR_W  = GROUPS * GROUP_W;
	localparam int HALF_W  = ADDR_W / 2;

	// Characters with a special meaning
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;

	// Result status codes
	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_BAD_CHAR  = 3'd1,
		STS_COLON_RUN = 3'd2,
		STS_LONG_GRP  = 3'd3,
		STS_MANY_GRP  = 3'd4,
		STS_EMPTY_GRP = 3'd5,
		STS_TOO_LONG  = 3'd6
	} status_t;

	// Progress through the bracketed all-zero form
	typedef enum logic [2:0] {
		BRK_NONE   = 3'd0,
		BRK_OPEN   = 3'd1,
		BRK_COLON1 = 3'd2,
		BRK_COLON2 = 3'd3,
		BRK_CLOSED = 3'd4,
		BRK_PLAIN  = 3'd5
	} brk_t;

	// Input item: one character
	typedef struct packed {
		logic [7:0] char_in;
		logic       last_char;
	} in_item_t;

	// Result item: parsed address and status
	typedef struct packed {
		logic [HALF_W-1:0] addr_high;
		logic [HALF_W-1:0] addr_low;
		logic [2:0]        status;
	} out_item_t;

	// Parser state. Head holds groups before "::" at their final place;
	// tail is a shift line of the groups after it, right aligned.
	typedef struct packed {
		logic [0:GROUPS-1][GROUP_W-1:0] head;
		logic [0:GROUPS-1][GROUP_W-1:0] tail;
		logic [GROUP_W-1:0]             accum;
		logic [2:0]                     digits;
		logic [3:0]                     groups;
		logic [1:0]                     colons;
		logic                           gap;
		status_t                        err;
		logic [CNT_W-1:0]               cnt;
		brk_t                           brk;
	} v6p_state_t;

endpackage

### rtl/v6p_step.sv
// ----------------------------------------------------------------------------
// v6p_step: per-character parser update
// Takes the current parser state and one character, gives the next state
// and, for the final character, the assembled address and status.
// ----------------------------------------------------------------------------
module v6p_step import v6p_pkg::*; (
	input  v6p_state_t cur,
	input  in_item_t   item,
	output v6p_state_t nxt,
	output out_item_t  result
);

	// Hex digit decode: bit 4 marks a valid digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, c[3:0] + 4'd9};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, c[3:0] + 4'd9};
		return r;
	endfunction

	// First error wins
	function automatic v6p_state_t set_err(input v6p_state_t st, input status_t code);
		v6p_state_t r;
		r = st;
		if (st.err == STS_OK) r.err = code;
		return r;
	endfunction

	// Close the group being assembled
	function automatic v6p_state_t commit_group(input v6p_state_t st);
		v6p_state_t r;
		r = st;
		if (st.groups >= 4'(GROUPS)) begin
			r = set_err(r, STS_MANY_GRP);
		end else begin
			if (st.gap) r.tail = {st.tail[1:GROUPS-1], st.accum};
			else r.head[st.groups[2:0]] = st.accum;
			r.groups = st.groups + 4'd1;
		end
		r.accum  = '0;
		r.digits = '0;
		return r;
	endfunction

	// One character while no error is pending
	function automatic v6p_state_t take_char(input v6p_state_t st, input logic [7:0] c,
		input logic first);
		v6p_state_t r;
		logic [4:0] hx;
		r  = st;
		hx = hex_value(c);
		if (first && c == CH_LBRACK) begin
			r.brk = BRK_OPEN;
		end else begin
			if (first) r.brk = BRK_PLAIN;
			if (r.brk != BRK_PLAIN && r.brk != BRK_NONE) begin
				// bracketed form must be exactly "[::]"
				case (r.brk)
					BRK_OPEN: begin
						if (c == CH_COLON) r.brk = BRK_COLON1;
						else r = set_err(r, STS_BAD_CHAR);
					end
					BRK_COLON1: begin
						if (c == CH_COLON) r.brk = BRK_COLON2;
						else r = set_err(r, STS_BAD_CHAR);
					end
					BRK_COLON2: begin
						if (c == CH_RBRACK) r.brk = BRK_CLOSED;
						else r = set_err(r, STS_BAD_CHAR);
					end
					default: r = set_err(r, STS_BAD_CHAR);
				endcase
			end else if (hx[4]) begin
				// digit; a single leading colon leaves an empty group
				if (r.colons == 2'd1 && r.groups == 4'd0 && !r.gap) begin
					r = set_err(r, STS_EMPTY_GRP);
				end else begin
					r.colons = '0;
					if (r.digits >= 3'd4) begin
						r = set_err(r, STS_LONG_GRP);
					end else begin
						r.accum  = {r.accum[GROUP_W-5:0], hx[3:0]};
						r.digits = r.digits + 3'd1;
					end
				end
			end else if (c == CH_COLON) begin
				if (r.colons >= 2'd2) begin
					r = set_err(r, STS_COLON_RUN);
				end else begin
					r.colons = r.colons + 2'd1;
					if (r.colons == 2'd1) begin
						if (r.digits != 3'd0) r = commit_group(r);
					end else if (r.gap) begin
						r = set_err(r, STS_EMPTY_GRP);
					end else begin
						r.gap = 1'b1;
					end
				end
			end else begin
				r = set_err(r, STS_BAD_CHAR);
			end
		end
		return r;
	endfunction

	// Character update, final checks and address assembly
	always_comb begin
		v6p_state_t s;
		logic [ADDR_W-1:0] addr;
		s = cur;
		if (cur.cnt >= CNT_W'(MAX_CHARS)) begin
			s = set_err(s, STS_TOO_LONG);
		end else begin
			s.cnt = cur.cnt + 1'b1;
			if (cur.err == STS_OK) s = take_char(s, item.char_in, cur.cnt == '0);
		end

		if (item.last_char && s.err == STS_OK) begin
			if (s.brk == BRK_OPEN || s.brk == BRK_COLON1 || s.brk == BRK_COLON2) begin
				s = set_err(s, STS_BAD_CHAR);
			end else if (s.brk != BRK_CLOSED) begin
				if (s.digits != 3'd0) s = commit_group(s);
				if (s.colons == 2'd1) s = set_err(s, STS_EMPTY_GRP);
				if (s.gap && s.groups > 4'd7) s = set_err(s, STS_MANY_GRP);
			end
		end

		// head and tail never overlap on a good address
		if (s.err == STS_OK && s.brk != BRK_CLOSED) addr = s.head | s.tail;
		else addr = '0;

		result.addr_high = addr[ADDR_W-1:HALF_W];
		result.addr_low  = addr[HALF_W-1:0];
		result.status    = s.err;

		// final character returns the parser to its start
		if (item.last_char) nxt = '0;
		else nxt = s;
	end

endmodule

### rtl/ipv6_text_address_parser.sv
// ----------------------------------------------------------------------------
// ipv6_text_address_parser: IPv6 text address parser, top level
// Input register, parser state, result register and handshakes.
// ----------------------------------------------------------------------------
// The block takes one character per item and accepts a new item every cycle.
// A character is registered in the input register, then folded into the parser
// state; the item flagged last_char passes from the input register into the
// result register, from which its result can be taken. The only stall is a
// final character waiting while the previous result is still untaken.
// Each result carries the address as two 64-bit halves and a status; any
// error gives an all-zero address. After a result the parser starts afresh.
module ipv6_text_address_parser import v6p_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	in_item_t   in_s1;
	logic       valid_s1;
	v6p_state_t state_q;
	v6p_state_t state_nxt;
	out_item_t  result;
	out_item_t  out_q;
	logic       out_valid_q;
	logic       advance;

	// Parser update
	v6p_step u_step (
		.cur    (state_q),
		.item   (in_s1),
		.nxt    (state_nxt),
		.result (result)
	);

	// Stage 1 moves on unless a final character meets a full result register that is not being taken
	assign advance  = valid_s1 && (!in_s1.last_char || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Control and parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance) state_q <= state_nxt;
			if (advance && in_s1.last_char) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) in_s1 <= in_data;
		if (advance && in_s1.last_char) out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### rtl/v6p_checker.sv
// ----------------------------------------------------------------------------
// v6p_checker: port-level checks for the IPv6 text address parser
// Watches the handshakes and results, bound to the top level.
// ----------------------------------------------------------------------------
module v6p_checker import v6p_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// A failed parse never shows address bits
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != STS_OK |->
			out_data.addr_high == '0 && out_data.addr_low == '0)
		else $error("error result with nonzero address");

	// Status stays within the defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 3'd7)
		else $error("undefined status code");

	// A new result is preceded by an accepted final character
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_data.last_char, 2))
		else $error("result without a final character");

	// With the result register empty, input is never stalled
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

endmodule

bind ipv6_text_address_parser v6p_checker u_v6p_checker (.*);

### test/ipv6_text_address_parser_tb.sv
// ----------------------------------------------------------------------------
// ipv6_text_address_parser_tb: self-checking testbench for the IPv6 parser
// Sends address text one character per item and predicts each parsed
// address and status in a scoreboard. The results are checked in order,
// field by field. A short directed set comes first, then random text under
// several idle and stall mixes on both sides.
// ----------------------------------------------------------------------------
module ipv6_text_address_parser_tb import v6p_pkg::*; ();

	// Kinds of random address text
	typedef enum {
		TXT_PLAIN,
		TXT_GAP,
		TXT_BRACKET,
		TXT_BROKEN,
		TXT_NOISE,
		TXT_LONG
	} text_kind_t;

	// Ways to damage an otherwise well-formed address
	typedef enum {
		MUT_SWAP_BYTE,
		MUT_ADD_COLON,
		MUT_DROP,
		MUT_TRAIL_COLON,
		MUT_LONG_GROUP
	} mut_t;

	// Scoreboard: tracks parser state and holds the expected addresses
	class parse_scoreboard;
		out_item_t          expected_addrs[$];
		int                 fail_count;
		logic [15:0]        grp_store[8];
		logic [15:0]        grp_accum;
		logic [2:0]         digits;
		logic [3:0]         groups;
		logic [1:0]         colons;
		logic [3:0]         gap_at;
		logic               gap_seen;
		status_t            err;
		logic [CNT_W-1:0]   n_chars;
		brk_t               brk;

		function new();
			fail_count = 0;
			clear();
		endfunction

		function void clear();
			foreach (grp_store[i])
				grp_store[i] = '0;
			grp_accum = '0;
			digits    = '0;
			groups    = '0;
			colons    = '0;
			gap_at    = '0;
			gap_seen  = 1'b0;
			err       = STS_OK;
			n_chars   = '0;
			brk       = BRK_NONE;
		endfunction

		// Only the first error is kept
		function void flag(status_t code);
			if (err == STS_OK)
				err = code;
		endfunction

		// Hex value of a character, 16 when it is no hex digit
		function logic [4:0] hex_digit(logic [7:0] c);
			if (c >= "0" && c <= "9")
				return {1'b0, c[3:0]};
			else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
				return {1'b0, c[3:0] + 4'd9};
			else
				return 5'd16;
		endfunction

		function void commit();
			if (groups >= 8) begin
				flag(STS_MANY_GRP);
			end else begin
				grp_store[groups] = grp_accum;
				groups++;
			end
			grp_accum = '0;
			digits    = '0;
		endfunction

		function void parse_char(logic [7:0] c, bit first);
			logic [4:0] v;
			logic [7:0] want;
			if (first && c == CH_LBRACK) begin
				brk = BRK_OPEN;
				return;
			end
			if (first)
				brk = BRK_PLAIN;
			// bracketed text must be exactly "[::]"
			if (brk >= BRK_OPEN && brk <= BRK_CLOSED) begin
				want = (brk == BRK_COLON2) ? CH_RBRACK : CH_COLON;
				if (brk != BRK_CLOSED && c == want)
					brk = brk_t'(brk + 1);
				else
					flag(STS_BAD_CHAR);
				return;
			end
			v = hex_digit(c);
			if (v < 5'd16) begin
				// digit after a lone leading colon
				if (colons == 1 && groups == 0 && !gap_seen) begin
					flag(STS_EMPTY_GRP);
					return;
				end
				colons = '0;
				if (digits >= 4) begin
					flag(STS_LONG_GRP);
					return;
				end
				grp_accum = {grp_accum[11:0], v[3:0]};
				digits++;
			end else if (c == CH_COLON) begin
				if (colons >= 2) begin
					flag(STS_COLON_RUN);
					return;
				end
				colons++;
				if (colons == 1) begin
					if (digits > 0)
						commit();
				end else if (gap_seen) begin
					flag(STS_EMPTY_GRP);
				end else begin
					gap_seen = 1'b1;
					gap_at   = groups;
				end
			end else begin
				flag(STS_BAD_CHAR);
			end
		endfunction

		// Accepted input item; the last character yields one expected address
		function void note_char(in_item_t item);
			bit          first;
			logic [15:0] addr[8];
			int          n;
			int          tail;
			out_item_t   res;
			if (n_chars >= MAX_CHARS) begin
				flag(STS_TOO_LONG);
			end else begin
				first = (n_chars == 0);
				n_chars++;
				if (err == STS_OK)
					parse_char(item.char_in, first);
			end
			if (!item.last_char)
				return;

			foreach (addr[p])
				addr[p] = '0;
			// end-of-text checks
			if (err == STS_OK) begin
				if (brk >= BRK_OPEN && brk <= BRK_COLON2) begin
					flag(STS_BAD_CHAR);
				end else if (brk != BRK_CLOSED) begin
					if (digits > 0)
						commit();
					if (colons == 1)
						flag(STS_EMPTY_GRP);
					if (gap_seen && groups > 7)
						flag(STS_MANY_GRP);
				end
			end
			// place groups; those after "::" are right aligned
			if (err == STS_OK && brk != BRK_CLOSED) begin
				n = (groups > 8) ? 8 : groups;
				if (gap_seen) begin
					tail = n - gap_at;
					for (int p = 0; p < 8; p++) begin
						if (p < gap_at)
							addr[p] = grp_store[p];
						else if (p >= 8 - tail)
							addr[p] = grp_store[(p - (8 - n)) & 7];
					end
				end else begin
					for (int p = 0; p < n; p++)
						addr[p] = grp_store[p];
				end
			end
			res.addr_high = {addr[0], addr[1], addr[2], addr[3]};
			res.addr_low  = {addr[4], addr[5], addr[6], addr[7]};
			res.status    = err;
			expected_addrs.push_back(res);
			clear();
		endfunction

		function void check_addr(out_item_t got);
			out_item_t want;
			if (expected_addrs.size() == 0) begin
				$display("%0t: result with none expected, got %h", $time, got);
				fail_count++;
				return;
			end
			want = expected_addrs.pop_front();
			if (got.addr_high !== want.addr_high) begin
				$display("%0t: addr_high expected %h, got %h",
					$time, want.addr_high, got.addr_high);
				fail_count++;
			end
			if (got.addr_low !== want.addr_low) begin
				$display("%0t: addr_low expected %h, got %h",
					$time, want.addr_low, got.addr_low);
				fail_count++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d, got %0d",
					$time, want.status, got.status);
				fail_count++;
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	parse_scoreboard sb;
	logic [7:0]      addr_text[$];
	int              send_idle_pct;
	int              sink_stall_pct;
	int              chars_sent;

	ipv6_text_address_parser uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #10 clk = ~clk;

	// Receiver: random stalls, changed at the falling edge
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_addr(out_data);
	end

	// Send one item; entered and left just after a falling edge
	task send_char(in_item_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = item;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_char(item);
		chars_sent++;
		@(negedge clk);
	endtask

	task send_text();
		in_item_t item;
		for (int i = 0; i < addr_text.size(); i++) begin
			item.char_in   = addr_text[i];
			item.last_char = (i == addr_text.size() - 1);
			send_char(item);
		end
	endtask

	task put_hex_group(int ndig);
		int         v;
		logic [7:0] ch;
		for (int i = 0; i < ndig; i++) begin
			v = $urandom_range(15);
			if (v < 10)
				ch = 8'("0" + v);
			else
				ch = 8'(($urandom_range(1) ? "a" : "A") + v - 10);
			addr_text.push_back(ch);
		end
	endtask

	task put_groups(int count);
		for (int i = 0; i < count; i++) begin
			if (i > 0)
				addr_text.push_back(CH_COLON);
			put_hex_group($urandom_range(1, 4));
		end
	endtask

	// Well-formed address with a "::"; now and then one group too many
	task put_gap_text();
		int head;
		int tail;
		head = $urandom_range(0, 7);
		tail = ($urandom_range(9) == 0) ? 8 - head : $urandom_range(0, 7 - head);
		put_groups(head);
		addr_text.push_back(CH_COLON);
		addr_text.push_back(CH_COLON);
		put_groups(tail);
	endtask

	task make_text(text_kind_t kind);
		int len;
		addr_text.delete();
		case (kind)
			TXT_PLAIN: begin
				put_groups(($urandom_range(9) == 0) ? 9 : $urandom_range(1, 8));
			end
			TXT_GAP: begin
				put_gap_text();
			end
			TXT_BRACKET: begin
				addr_text = '{CH_LBRACK, CH_COLON, CH_COLON, CH_RBRACK};
				// sometimes cut short or extended
				if ($urandom_range(1)) begin
					if ($urandom_range(1))
						addr_text.delete($urandom_range(1, 3));
					else
						addr_text.insert($urandom_range(1, 4), 8'($urandom_range(255)));
				end
			end
			TXT_BROKEN: begin
				if ($urandom_range(1))
					put_gap_text();
				else
					put_groups($urandom_range(1, 8));
				case (mut_t'($urandom_range(4)))
					MUT_SWAP_BYTE:
						addr_text[$urandom_range(addr_text.size() - 1)] =
							8'($urandom_range(255));
					MUT_ADD_COLON:
						addr_text.insert($urandom_range(addr_text.size()), CH_COLON);
					MUT_DROP: begin
						if (addr_text.size() > 1)
							addr_text.delete($urandom_range(addr_text.size() - 1));
					end
					MUT_TRAIL_COLON:
						addr_text.push_back(CH_COLON);
					default: begin
						addr_text.push_back(CH_COLON);
						put_hex_group(5);
					end
				endcase
			end
			TXT_NOISE: begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					addr_text.push_back(8'($urandom_range(255)));
			end
			default: begin
				// runs up to or past the character limit
				len = $urandom_range(60, 70);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(4) == 0)
						addr_text.push_back(CH_COLON);
					else
						put_hex_group(1);
				end
			end
		endcase
	endtask

	function text_kind_t pick_kind();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return TXT_PLAIN;
		else if (roll < 70)
			return TXT_GAP;
		else if (roll < 76)
			return TXT_BRACKET;
		else if (roll < 91)
			return TXT_BROKEN;
		else if (roll < 98)
			return TXT_NOISE;
		else
			return TXT_LONG;
	endfunction

	// Directed texts: all-zero forms, lone colons, digit case, errors
	string directed_texts[] = '{"[::]", "::", ":", ":1", "1:", "fFfF",
		"12345", ":::", "]", "[:]"};

	// Idle mixes: sender idle percent, receiver stall percent
	int phase_idle[4]  = '{0, 76, 0, 20};
	int phase_stall[4] = '{0, 0, 76, 20};

	initial begin
		sb             = new();
		send_idle_pct  = 0;
		sink_stall_pct = 0;
		chars_sent     = 0;
		in_valid       = 1'b0;
		in_data        = '0;
		arst_n         = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed part
		foreach (directed_texts[k]) begin
			addr_text.delete();
			for (int i = 0; i < directed_texts[k].len(); i++)
				addr_text.push_back(directed_texts[k][i]);
			send_text();
		end

		// random part, one quarter per idle mix
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = phase_idle[ph];
			sink_stall_pct = phase_stall[ph];
			chars_sent     = 0;
			while (chars_sent < 225) begin
				make_text(pick_kind());
				send_text();
			end
		end
		in_valid = 1'b0;

		// drain, then allow for the pipeline latency
		while (sb.expected_addrs.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#(20 * 400000);
		$display("FAIL");
		$finish;
	end

endmodule

### ipv6_text_address_parser.f
rtl/v6p_pkg.sv
rtl/v6p_step.sv
rtl/ipv6_text_address_parser.sv
rtl/v6p_checker.sv
test/ipv6_text_address_parser_tb.sv
